// ===== design/sfr_pkg.sv =====
// Shared constants, types and helpers for the stream find-and-replace unit.
package sfr_pkg;

    localparam int MAX_STRING_BYTES = 8;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 4;
    localparam int IDX_W            = (MAX_STRING_BYTES > 1) ? $clog2(MAX_STRING_BYTES) : 1;
    localparam int QDEPTH           = MAX_STRING_BYTES + 1;
    localparam int QCNT_W           = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_reg;

    typedef logic [MAX_STRING_BYTES-1:0][BYTE_W-1:0] t_bytes;

    // One burst of results produced by a single input transaction.
    typedef struct packed {
        t_bytes           data;
        logic [LEN_W-1:0] count;
        logic             last;
    } t_burst;

    // Map a length register onto 1..MAX_STRING_BYTES.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > LEN_W'(MAX_STRING_BYTES)) begin
            r = LEN_W'(MAX_STRING_BYTES);
        end
        return r;
    endfunction

endpackage

// ===== design/sfr_in_if.sv =====
// Input byte stream channel.
interface sfr_in_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

// ===== design/sfr_out_if.sv =====
// Output byte stream channel.
interface sfr_out_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_final;

    modport source (output valid, output out_byte, output out_final, input ready);
    modport sink   (input valid, input out_byte, input out_final, output ready);
endinterface

// ===== design/sfr_win_cell.sv =====
// One window cell: holds a byte, shifts from its neighbor, compares against a pattern byte.
module sfr_win_cell import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_pat,
    input  logic              i_cmp_en,
    output logic [BYTE_W-1:0] o_byte,
    output logic [BYTE_W-1:0] o_next,
    output logic              o_eq
);
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_next = n_byte;
    // Cells outside the compared span always agree.
    assign o_eq   = !i_cmp_en || (n_byte == i_pat);
endmodule

// ===== design/sfr_out_queue.sv =====
// Output queue: a row of byte slots draining toward slot 0, loaded one burst at a time.
module sfr_out_queue import sfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_burst      i_burst,
    output logic        o_room,
    sfr_out_if.source   o_out
);
    logic [BYTE_W-1:0] r_q    [QDEPTH];
    logic [BYTE_W-1:0] n_q    [QDEPTH];
    logic              r_last [QDEPTH];
    logic              n_last [QDEPTH];
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              w_pop;
    logic [QCNT_W-1:0] w_base;
    logic [QCNT_W-1:0] w_add;

    assign w_pop  = (r_cnt != '0) && o_out.ready;
    assign w_base = r_cnt - QCNT_W'(w_pop);
    assign w_add  = i_push ? QCNT_W'(i_burst.count) : '0;

    always_comb begin
        logic [QCNT_W:0] off;
        logic [IDX_W-1:0] sel;
        for (int s = 0; s < QDEPTH; s++) begin
            off = (QCNT_W+1)'(s) - {1'b0, w_base};
            sel = off[IDX_W-1:0];
            // Advance toward the head when the head is taken.
            if (w_pop && s < QDEPTH - 1) begin
                n_q[s]    = r_q[s + 1];
                n_last[s] = r_last[s + 1];
            end else begin
                n_q[s]    = r_q[s];
                n_last[s] = r_last[s];
            end
            if (i_push && (QCNT_W+1)'(s) >= {1'b0, w_base}
                    && off < (QCNT_W+1)'(i_burst.count)) begin
                n_q[s]    = i_burst.data[sel];
                n_last[s] = i_burst.last
                            && (off == (QCNT_W+1)'(i_burst.count) - (QCNT_W+1)'(1));
            end
        end
        n_cnt = w_base + w_add;
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < QDEPTH; s++) begin
            r_q[s]    <= n_q[s];
            r_last[s] <= n_last[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_room          = (r_cnt <= QCNT_W'(1));
    assign o_out.valid     = (r_cnt != '0);
    assign o_out.out_byte  = r_q[0];
    assign o_out.out_final = r_last[0];

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("output queue count out of range");
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ({1'b0, w_base} + (QCNT_W+1)'(i_burst.count)) <= (QCNT_W+1)'(QDEPTH))
        else $error("burst overflows output queue");
`endif
endmodule

// ===== design/stream_find_and_replace_unit.sv =====
// Stream find-and-replace top level: config registers, window cell row and output queue.
// Each result byte is registered in the output queue before it is offered on the output.
// Throughput: one input byte per cycle while the output is ready and each byte yields at most
//   one result; a burst of n results (replacement or final flush) drains byte by byte.
// Input ready is high while at most one result is queued, so it drops when the output stalls.
// Reset (synchronous, active low) empties the window and the queue and sets the registers to
//   pattern 0, pattern length 1, replacement 0, replacement length 1.
module stream_find_and_replace_unit import sfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfr_in_if.sink                i_in,
    sfr_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [CFG_DATA_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0]      r_pat_len;
    logic [CFG_DATA_W-1:0] r_rep_bytes;
    logic [LEN_W-1:0]      r_rep_len;
    logic [LEN_W-1:0]      r_fill;
    logic [LEN_W-1:0]      n_fill;

    t_bytes                w_pat;
    t_bytes                w_rep;
    t_bytes                w_cell;
    t_bytes                w_next;
    logic [MAX_STRING_BYTES-1:0] w_eq;
    logic [LEN_W-1:0]      w_plen;
    logic [LEN_W-1:0]      w_rlen;
    logic [LEN_W-1:0]      w_keep;
    logic [LEN_W-1:0]      w_m;
    logic                  w_full;
    logic                  w_match;
    logic                  w_accept;
    logic                  w_fin;
    logic                  w_room;
    t_burst                w_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= LEN_W'(1);
            r_rep_bytes <= '0;
            r_rep_len   <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_PATTERN_BYTES:      r_pat_bytes <= i_cfg_data;
                REG_PATTERN_LENGTH:     r_pat_len   <= i_cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  r_rep_bytes <= i_cfg_data;
                REG_REPLACEMENT_LENGTH: r_rep_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_pat    = r_pat_bytes[MAX_STRING_BYTES*BYTE_W-1:0];
    assign w_rep    = r_rep_bytes[MAX_STRING_BYTES*BYTE_W-1:0];
    assign w_plen   = clamp_len(r_pat_len);
    assign w_rlen   = clamp_len(r_rep_len);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_fin    = i_in.in_final;
    assign i_in.ready = w_room;

    // The window is right-aligned: the newest byte always lands in the last cell.
    for (genvar j = 0; j < MAX_STRING_BYTES; j++) begin : g_cell
        logic [LEN_W:0]    w_sum;
        logic [IDX_W-1:0]  w_pidx;
        logic              w_cmp;
        logic [BYTE_W-1:0] w_in;

        assign w_sum  = (LEN_W+1)'(j) + {1'b0, w_plen};
        assign w_cmp  = (w_sum >= (LEN_W+1)'(MAX_STRING_BYTES));
        assign w_pidx = IDX_W'(w_sum - (LEN_W+1)'(MAX_STRING_BYTES));

        if (j == MAX_STRING_BYTES - 1) begin : g_tail
            assign w_in = i_in.in_byte;
        end else begin : g_body
            assign w_in = w_cell[j + 1];
        end

        sfr_win_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_accept),
            .i_byte   (w_in),
            .i_pat    (w_pat[w_pidx]),
            .i_cmp_en (w_cmp),
            .o_byte   (w_cell[j]),
            .o_next   (w_next[j]),
            .o_eq     (w_eq[j])
        );
    end

    always_comb begin
        logic [LEN_W:0] src;
        // Drop the oldest excess bytes so the new byte fills the window at most.
        w_keep  = (r_fill >= w_plen) ? (w_plen - LEN_W'(1)) : r_fill;
        w_m     = w_keep + LEN_W'(1);
        w_full  = (w_m == w_plen);
        w_match = w_full && (&w_eq);

        for (int i = 0; i < MAX_STRING_BYTES; i++) begin
            src = (LEN_W+1)'(MAX_STRING_BYTES) - {1'b0, w_m} + (LEN_W+1)'(i);
            w_burst.data[i] = w_match ? w_rep[i] : w_next[src[IDX_W-1:0]];
        end
        w_burst.last = w_fin;

        priority if (w_match) begin
            w_burst.count = w_rlen;
            n_fill        = '0;
        end else if (w_fin) begin
            w_burst.count = w_m;
            n_fill        = '0;
        end else if (w_full) begin
            w_burst.count = LEN_W'(1);
            n_fill        = w_plen - LEN_W'(1);
        end else begin
            w_burst.count = '0;
            n_fill        = w_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
        end
    end

    sfr_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_burst (w_burst),
        .o_room  (w_room),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_STRING_BYTES - 1))
        else $error("window fill out of range");
    a_final_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.in_final) |=> (r_fill == '0))
        else $error("window not empty after final byte");
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.in_final) |=> o_out.valid)
        else $error("final byte produced no result");
`endif
endmodule
